>>> src/chip8_instruction_executor_assert.svh
// Assertion macros for the CHIP-8 executor.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c8 assertion failed");
`define C8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c8 assertion failed");
`else
`define C8_ASSERT_IMPL(lbl, ante, cons)
`define C8_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/c8_pkg.sv
// Package for the CHIP-8 executor: operation codes, font table, control structs.
// No dependencies.
package c8_pkg;
  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [11:0] PC_RESET = 12'h200;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EXEC  = 2'd1,
    OP_READ  = 2'd2,
    OP_DISP  = 2'd3
  } op_t;

  // Memory port selector driven by the controller.
  typedef enum logic [2:0] {
    MA_HOST = 3'd0,
    MA_PC   = 3'd1,
    MA_PC1  = 3'd2,
    MA_IDX  = 3'd3,
    MA_INIT = 3'd4
  } maddr_t;

  // Memory write data selector driven by the controller.
  typedef enum logic [1:0] {
    MW_HOST = 2'd0,
    MW_BCD  = 2'd1,
    MW_REG  = 2'd2,
    MW_INIT = 2'd3
  } mwsel_t;

  // Font glyph byte for memory address a (first 128 bytes).
  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [79:0] rows;
    logic [7:0] b;
    begin
      case (a[6:3])
        4'h0: rows = 80'hF0909090F0_0000000000;
        4'h1: rows = 80'h2060202070_0000000000;
        4'h2: rows = 80'hF010F080F0_0000000000;
        4'h3: rows = 80'hF010F010F0_0000000000;
        4'h4: rows = 80'h9090F01010_0000000000;
        4'h5: rows = 80'hF080F010F0_0000000000;
        4'h6: rows = 80'hF080F090F0_0000000000;
        4'h7: rows = 80'hF010204040_0000000000;
        4'h8: rows = 80'hF090F090F0_0000000000;
        4'h9: rows = 80'hF090F010F0_0000000000;
        4'hA: rows = 80'hF090F09090_0000000000;
        4'hB: rows = 80'hE090E090E0_0000000000;
        4'hC: rows = 80'hF0808080F0_0000000000;
        4'hD: rows = 80'hE0909090E0_0000000000;
        4'hE: rows = 80'hF080F080F0_0000000000;
        default: rows = 80'hF080F08080_0000000000;
      endcase
      case (a[2:0])
        3'd0: b = rows[79:72];
        3'd1: b = rows[71:64];
        3'd2: b = rows[63:56];
        3'd3: b = rows[55:48];
        3'd4: b = rows[47:40];
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    maddr_t     maddr;
    logic [3:0] moff;      // offset added to I for memory accesses
    logic       mwe;
    mwsel_t     mwsel;     // host data, BCD digit, register, or reset image
    logic       dwe;       // display write
    logic       dclr;      // display address comes from counter
    logic       load_hi;
    logic       load_lo;
    logic       exec;      // perform instruction effects
    logic       reg_ld;    // load V[moff] from memory read data
    logic       draw_pix;  // draw: apply row byte to display byte pair
    logic       draw_fin;  // draw: commit VF
    logic       capture;   // latch result
    logic       clr_changed;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [15:0] opcode;
  } sts_t;
endpackage

>>> src/c8_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read in the write cycle returns the old contents.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/c8_datapath.sv
// Datapath of the CHIP-8 executor: memories, registers, stack, timers, result.
// Depends on c8_pkg and c8_ram.
module c8_datapath #(
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  c8_pkg::cmd_t cmd,
  input  logic [11:0]  cnt,       // sweep counter from the controller
  input  logic [1:0]   in_op,
  input  logic [11:0]  in_addr,
  input  logic [7:0]   in_wdata,
  input  logic [15:0]  in_keys,
  input  logic [3:0]   in_wkey,
  input  logic [7:0]   in_rnd,
  output c8_pkg::sts_t sts,
  output logic [38:0]  res       // read_data, pc, opcode, illegal, changed, sound
);
  import c8_pkg::*;
  localparam int SPW = $clog2(STACK_DEPTH);

  logic [7:0]  v_r [16];
  logic [15:0] i_r;
  logic [11:0] pc_r;
  logic [11:0] stk_r [STACK_DEPTH];
  logic [SPW-1:0] sp_r;
  logic [7:0]  dt_r, st_r;
  logic [15:0] opc_r;
  logic        chg_r, hit_r;
  logic [7:0]  row_r;
  logic [38:0] res_r;

  // Main memory port.
  logic [11:0] ma;
  logic [7:0]  mwd, mrd;
  logic [15:0] ioff;
  logic [3:0]  x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [7:0]  bcd;
  assign x = opc_r[11:8];
  assign y = opc_r[7:4];
  assign n = opc_r[3:0];
  assign nn = opc_r[7:0];
  assign vx = v_r[x];
  assign vy = v_r[y];
  assign ioff = i_r + {12'd0, cmd.moff};

  always_comb begin
    case (cmd.maddr)
      MA_HOST: ma = in_addr;
      MA_PC:   ma = pc_r;
      MA_PC1:  ma = pc_r + 12'd1;
      MA_IDX:  ma = ioff[11:0];
      default: ma = cnt;
    endcase
  end

  // BCD digits of VX, one chosen by offset.
  always_comb begin
    logic [7:0] h, t, q;
    logic [15:0] p;
    h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    t = vx - h * 8'd100;
    // Tens digit by reciprocal multiplication, exact for values below 100.
    p = {8'd0, t} * 16'd205;
    q = {3'd0, p[15:11]};
    case (cmd.moff[1:0])
      2'd0: bcd = h;
      2'd1: bcd = q;
      default: bcd = t - q * 8'd10;
    endcase
  end

  always_comb begin
    case (cmd.mwsel)
      MW_HOST: mwd = in_wdata;
      MW_BCD:  mwd = bcd;
      MW_REG:  mwd = v_r[cmd.moff];
      default: mwd = (cnt < 12'd128) ? font_byte(cnt[6:0]) : 8'h00;
    endcase
  end

  c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk(clk), .we(cmd.mwe), .addr(ma), .wdata(mwd), .rdata(mrd));

  // Display: draw touches the byte picked by row and half; clear sweeps cnt[8:1].
  logic [7:0] da, dwd, drd;
  logic [5:0] px;
  logic [4:0] py;
  logic [2:0] sh;
  logic [15:0] spr;
  assign px = vx[5:0];
  assign py = vy[4:0] + cnt[11:7];
  assign sh = px[2:0];
  assign spr = {row_r, 8'd0} >> sh;
  always_comb begin
    if (cmd.dclr) da = cnt[8:1];
    else da = {py, px[5:3] + {2'd0, cnt[6]}};
    dwd = cmd.dclr ? 8'd0 : (drd ^ (cnt[6] ? spr[7:0] : spr[15:8]));
  end
  c8_ram #(.WIDTH(8), .DEPTH(256)) u_disp (
    .clk(clk), .we(cmd.dwe),
    .addr(cmd.maddr == MA_HOST ? in_addr[7:0] : da), .wdata(dwd), .rdata(drd));

  assign sts.opcode = opc_r;

  logic [11:0] nxt, nxt2;
  logic        ill;
  logic        kd;
  assign nxt = pc_r + 12'd2;
  assign nxt2 = pc_r + 12'd4;
  assign kd = in_keys[vx[3:0]];

  always_comb begin
    ill = 1'b0;
    case (opc_r[15:12])
      4'h0: ill = (opc_r != 16'h00E0) && (opc_r != 16'h00EE);
      4'h8: ill = !((n <= 4'h7) || (n == 4'hE));
      4'hE: ill = (nn != 8'h9E) && (nn != 8'hA1);
      4'hF: ill = !((nn == 8'h07) || (nn == 8'h0A) || (nn == 8'h15) || (nn == 8'h18) ||
                    (nn == 8'h1E) || (nn == 8'h29) || (nn == 8'h33) || (nn == 8'h55) ||
                    (nn == 8'h65));
      default: ill = 1'b0;
    endcase
  end

  // Register state updates.
  always_ff @(posedge clk) begin
    logic [8:0] r9;
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) v_r[k] <= 8'd0;
      for (int k = 0; k < STACK_DEPTH; k++) stk_r[k] <= 12'd0;
      i_r <= 16'd0;
      pc_r <= PC_RESET;
      sp_r <= SPW'(STACK_DEPTH - 1);
      dt_r <= 8'd0;
      st_r <= 8'd0;
      opc_r <= 16'd0;
      chg_r <= 1'b0;
      hit_r <= 1'b0;
      row_r <= 8'd0;
      res_r <= '0;
    end else begin
      if (cmd.clr_changed) begin
        chg_r <= 1'b0;
        hit_r <= 1'b0;
      end
      if (cmd.load_hi) opc_r[15:8] <= mrd;
      if (cmd.load_lo) opc_r[7:0] <= mrd;
      if (cmd.reg_ld) v_r[cmd.moff] <= mrd;
      if (cmd.dclr && cmd.dwe && drd != 8'd0) chg_r <= 1'b1;
      if (cmd.draw_pix) begin
        // mrd holds the sprite row during the first half.
        if (!cnt[6]) row_r <= mrd;
      end
      if (cmd.dwe && !cmd.dclr) begin
        logic [7:0] b;
        b = cnt[6] ? spr[7:0] : spr[15:8];
        if ((drd & b) != 8'd0) hit_r <= 1'b1;
        if (b != 8'd0) chg_r <= 1'b1;
      end
      if (cmd.draw_fin) begin
        v_r[15] <= {7'd0, hit_r};
      end
      if (cmd.exec) begin
        if (!ill) begin
          pc_r <= nxt;
          case (opc_r[15:12])
            4'h0: begin
              if (opc_r == 16'h00EE) begin
                pc_r <= stk_r[sp_r];
                sp_r <= (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - 1'b1;
              end
            end
            4'h1: pc_r <= opc_r[11:0];
            4'h2: begin
              logic [SPW-1:0] s;
              s = (32'(sp_r) + 1 >= STACK_DEPTH) ? '0 : sp_r + 1'b1;
              sp_r <= s;
              stk_r[s] <= nxt;
              pc_r <= opc_r[11:0];
            end
            4'h3: if (vx == nn) pc_r <= nxt2;
            4'h4: if (vx != nn) pc_r <= nxt2;
            4'h5: if (vx == vy) pc_r <= nxt2;
            4'h6: v_r[x] <= nn;
            4'h7: v_r[x] <= vx + nn;
            4'h8: begin
              case (n)
                4'h0: v_r[x] <= vy;
                4'h1: v_r[x] <= vx | vy;
                4'h2: v_r[x] <= vx & vy;
                4'h3: v_r[x] <= vx ^ vy;
                4'h4: begin
                  r9 = {1'b0, vx} + {1'b0, vy};
                  v_r[x] <= r9[7:0];
                  v_r[15] <= {7'd0, r9[8]};
                end
                4'h5: begin
                  v_r[x] <= vx - vy;
                  v_r[15] <= {7'd0, vx >= vy};
                end
                4'h6: begin
                  v_r[x] <= {1'b0, vx[7:1]};
                  v_r[15] <= {7'd0, vx[0]};
                end
                4'h7: begin
                  v_r[x] <= vy - vx;
                  v_r[15] <= {7'd0, vy >= vx};
                end
                default: begin
                  v_r[x] <= {vx[6:0], 1'b0};
                  v_r[15] <= {7'd0, vx[7]};
                end
              endcase
            end
            4'h9: if (vx != vy) pc_r <= nxt2;
            4'hA: i_r <= {4'd0, opc_r[11:0]};
            4'hB: pc_r <= opc_r[11:0] + {4'd0, v_r[0]};
            4'hC: v_r[x] <= in_rnd & nn;
            4'hE: begin
              if (nn == 8'h9E && kd) pc_r <= nxt2;
              if (nn == 8'hA1 && !kd) pc_r <= nxt2;
            end
            4'hF: begin
              case (nn)
                8'h07: v_r[x] <= dt_r;
                8'h0A: v_r[x] <= {4'd0, in_wkey};
                8'h1E: i_r <= i_r + {8'd0, vx};
                8'h29: i_r <= {5'd0, vx, 3'd0};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        // Timers tick on every executed instruction, after a load by FX15 or FX18.
        if (opc_r[15:12] == 4'hF && nn == 8'h15) dt_r <= (vx != 8'd0) ? vx - 8'd1 : 8'd0;
        else dt_r <= (dt_r != 8'd0) ? dt_r - 8'd1 : 8'd0;
        if (opc_r[15:12] == 4'hF && nn == 8'h18) st_r <= (vx != 8'd0) ? vx - 8'd1 : 8'd0;
        else st_r <= (st_r != 8'd0) ? st_r - 8'd1 : 8'd0;
      end
      if (cmd.capture) begin
        logic [7:0] rd;
        logic       ex;
        ex = (in_op == OP_EXEC);
        rd = (in_op == OP_READ) ? mrd : (in_op == OP_DISP) ? drd : 8'd0;
        res_r <= {rd, pc_r, ex ? opc_r : 16'd0, ex & ill, ex & chg_r, st_r != 8'd0};
      end
    end
  end

  assign res = res_r;
endmodule

>>> src/c8_ctrl.sv
// Controller state machine of the CHIP-8 executor.
// Depends on c8_pkg.
module c8_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  input  logic [1:0]   in_op,
  input  c8_pkg::sts_t sts,
  input  logic         out_free,  // output register empty or being taken
  output logic         busy,
  output logic         init_done,
  output logic         res_load,
  output logic [11:0]  cnt,
  output c8_pkg::cmd_t cmd
);
  import c8_pkg::*;

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HOST  = 11'b00000000100,
    S_FHI   = 11'b00000001000,
    S_FLO   = 11'b00000010000,
    S_DEC   = 11'b00000100000,
    S_CLR   = 11'b00001000000,
    S_DRAW  = 11'b00010000000,
    S_MEM   = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic [15:0] opc;
  assign opc = sts.opcode;
  assign cnt = cnt_r;
  assign busy = (st_r != S_IDLE);
  assign init_done = (st_r != S_INIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      cnt_r <= 12'd0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.maddr = MA_HOST;
    res_load = 1'b0;
    unique case (st_r)
      S_INIT: begin
        // Memory and display clearing pass, font loaded in the low bytes.
        cmd.maddr = MA_INIT;
        cmd.mwe = 1'b1;
        cmd.mwsel = MW_INIT;
        cmd.dclr = 1'b1;
        cmd.dwe = 1'b1;
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == 12'hFFF) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.clr_changed = 1'b1;
        if (in_fire) begin
          if (in_op == OP_EXEC) begin
            st_nxt = S_FHI;
          end else begin
            st_nxt = S_HOST;
          end
        end
      end
      S_HOST: begin
        // Registered read done; write happened at accept.
        st_nxt = S_OUT;
      end
      S_FHI: begin
        cmd.maddr = MA_PC;
        st_nxt = S_FLO;
      end
      S_FLO: begin
        cmd.maddr = MA_PC1;
        cmd.load_hi = 1'b1;
        st_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.load_lo = 1'b1;
        cnt_nxt = 12'd0;
        st_nxt = S_MEM;
      end
      S_MEM: begin
        // Opcode now stable: route to the long operations or finish.
        cnt_nxt = 12'd0;
        if (opc == 16'h00E0) st_nxt = S_CLR;
        else if (opc[15:12] == 4'hD) st_nxt = S_DRAW;
        else if (opc[15:12] == 4'hF &&
                 (opc[7:0] == 8'h33 || opc[7:0] == 8'h55 || opc[7:0] == 8'h65))
          st_nxt = S_FIN;
        else begin
          cmd.exec = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_CLR: begin
        // Read each display byte, then write zero in the following cycle.
        cmd.dclr = 1'b1;
        cmd.maddr = MA_PC;
        cmd.dwe = cnt_r[0];
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r == 12'd511) begin
          cmd.exec = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_DRAW: begin
        // cnt: [11:7] row, [6] half, [1:0] phase; row fetch, then two bytes RMW.
        cmd.maddr = MA_IDX;
        cmd.moff = cnt_r[10:7];
        cmd.draw_pix = (cnt_r[1:0] == 2'd2) && !cnt_r[6];
        cmd.dwe = (cnt_r[1:0] == 2'd3);
        cnt_nxt = cnt_r + 12'd1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = cnt_r[6] ? {cnt_r[11:7] + 5'd1, 7'd0} : {cnt_r[11:7], 1'b1, 6'd0};
        end
        if (cnt_r[11:7] == {1'b0, opc[3:0]}) begin
          cmd.dwe = 1'b0;
          cmd.draw_pix = 1'b0;
          cmd.draw_fin = 1'b1;
          cmd.exec = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_FIN: begin
        // BCD, store and load block moves, one register at a time.
        cmd.maddr = MA_IDX;
        cmd.moff = cnt_r[4:1];
        cnt_nxt = cnt_r + 12'd1;
        if (opc[7:0] == 8'h33) begin
          cmd.mwsel = MW_BCD;
          cmd.mwe = !cnt_r[0];
          if (cnt_r[4:1] == 4'd2 && cnt_r[0]) begin
            cmd.exec = 1'b1;
            st_nxt = S_OUT;
          end
        end else if (opc[7:0] == 8'h55) begin
          cmd.mwsel = MW_REG;
          cmd.mwe = !cnt_r[0];
          if (cnt_r[4:1] == opc[11:8] && cnt_r[0]) begin
            cmd.exec = 1'b1;
            st_nxt = S_OUT;
          end
        end else begin
          cmd.reg_ld = cnt_r[0];
          if (cnt_r[4:1] == opc[11:8] && cnt_r[0]) begin
            cmd.exec = 1'b1;
            st_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.capture = 1'b1;
          res_load = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // Host write happens at the accepting edge.
    if (st_r == S_IDLE && in_fire && in_op == OP_WRITE) cmd.mwe = 1'b1;
    if (st_r == S_IDLE && in_fire) cmd.maddr = MA_HOST;
    if (st_r == S_HOST) cmd.maddr = MA_HOST;
    cmd.mwsel = (st_r == S_IDLE) ? MW_HOST : cmd.mwsel;
  end
endmodule

>>> src/chip8_instruction_executor.sv
// Top level of the CHIP-8 executor: stream ports, output register, assertions.
// Depends on c8_pkg, c8_ctrl, c8_datapath, c8_ram and the assertion header.
//
//   Channel  Direction  Beat contents
//   in_      slave      operation, address, write_data, keys_down, waited_key, random_byte
//   out_     master     read_data, program_counter, executed_opcode, flags
//
// Reads and writes pass through a host state; an instruction is fetched as two bytes,
// decoded and executed. Clear adds a sweep over the display, draw a row fetch and two
// byte read-modify-writes per sprite row, block moves one byte at a time.
// After reset a pass clears memory and display and loads the font.
// One item is in work at a time; a held result stalls the next completion.
module chip8_instruction_executor #(
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // operation, address, write_data, keys_down,
                                 // waited_key, random_byte, 6 zero bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // read_data, program_counter, executed_opcode,
                                 // illegal_opcode, display_changed, sound_on, zero
);
  import c8_pkg::*;

  logic         in_fire, busy, init_done, res_load;
  logic [11:0]  cnt;
  cmd_t         cmd;
  sts_t         sts;
  logic [38:0]  res;
  logic         ov_r;
  logic [49:0]  item_r;
  logic [49:0]  item;

  assign in_tready = init_done && !busy;
  assign in_fire = in_tvalid && in_tready;
  assign item = in_fire ? in_tdata[49:0] : item_r;

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_tdata[49:0];
  end

  c8_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_tdata[1:0]),
    .sts(sts), .out_free(!ov_r || out_tready), .busy(busy),
    .init_done(init_done), .res_load(res_load), .cnt(cnt), .cmd(cmd));

  c8_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cnt(cnt),
    .in_op(item[1:0]), .in_addr(item[13:2]), .in_wdata(item[21:14]),
    .in_keys(item[37:22]), .in_wkey(item[41:38]), .in_rnd(item[49:42]),
    .sts(sts), .res(res));

  // Output valid flag; payload lives in the datapath result register.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {1'b0, res[0], res[1], res[2], res[18:3], res[30:19], res[38:31]};

  `include "chip8_instruction_executor_assert.svh"
  `C8_ASSERT_IMPL(a_no_accept_busy, busy, !in_tready)
  `C8_ASSERT_NEXT(a_load_sets_valid, res_load, out_tvalid)
  `C8_ASSERT_IMPL(a_no_accept_init, !init_done, !in_tready)
endmodule

>>> tb/chip8_instruction_executor_tb.sv
// Testbench for chip8_instruction_executor: loads short random programs beat by beat,
// executes them and checks every result beat against an in-bench CHIP-8 model.
// Depends on c8_pkg and the RTL of chip8_instruction_executor.
module chip8_instruction_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c8_pkg::*;

  // Opcode families (top nibble) and sub-operations.
  localparam logic [3:0] FAM_SYS = 4'h0, FAM_JP = 4'h1, FAM_CALL = 4'h2, FAM_SEB = 4'h3;
  localparam logic [3:0] FAM_SNEB = 4'h4, FAM_SER = 4'h5, FAM_LDB = 4'h6, FAM_ADDB = 4'h7;
  localparam logic [3:0] FAM_ALU = 4'h8, FAM_SNER = 4'h9, FAM_LDI = 4'hA, FAM_JPV0 = 4'hB;
  localparam logic [3:0] FAM_RND = 4'hC, FAM_DRW = 4'hD, FAM_KEY = 4'hE, FAM_MISC = 4'hF;
  localparam logic [15:0] OPC_CLS = 16'h00E0, OPC_RET = 16'h00EE;
  localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;
  localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
  localparam logic [7:0] MS_GETDT = 8'h07, MS_WAITK = 8'h0A, MS_SETDT = 8'h15;
  localparam logic [7:0] MS_SETST = 8'h18, MS_ADDI = 8'h1E, MS_FONT = 8'h29;
  localparam logic [7:0] MS_BCD = 8'h33, MS_STORE = 8'h55, MS_LOAD = 8'h65;
  localparam int N_RANDOM = 650;

  // Members run from the highest bits down, so the last member, op, lands lowest.
  typedef struct packed {
    logic [7:0]  rnd;
    logic [3:0]  wkey;
    logic [15:0] keys;
    logic [7:0]  wdata;
    logic [11:0] addr;
    op_t         op;
  } cpu_cmd_t;

  typedef struct packed {
    logic        snd;
    logic        chg;
    logic        ill;
    logic [15:0] opc;
    logic [11:0] pc;
    logic [7:0]  rd;
  } cpu_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  chip8_instruction_executor dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow CPU state.
  logic [7:0]  mem [4096];
  logic [7:0]  disp [256];
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [11:0] stk [16];
  logic [3:0]  sp;
  logic [7:0]  dtimer, stimer;

  cpu_cmd_t    cmd_q[$];
  cpu_status_t status_q[$];
  int          n_total, n_sent, n_fail;

  // Applies one command to the shadow CPU and returns the status beat it produces.
  task automatic cpu_step(input cpu_cmd_t c, output cpu_status_t r);
    logic [11:0] pcv, nxt, nnn, a;
    logic [15:0] opc;
    logic [3:0]  x, y;
    logic [7:0]  nn, vx, vy, res, line, bitm;
    logic [8:0]  sum;
    logic        f, setf, ill, chg, hit;
    int          row, col, px, py, idx, i;
    r = '0;
    ill = 1'b0;
    chg = 1'b0;
    case (c.op)
      OP_WRITE: mem[c.addr] = c.wdata;
      OP_READ:  r.rd = mem[c.addr];
      OP_DISP:  r.rd = disp[c.addr[7:0]];
      default: begin
        pcv = pc;
        nxt = pc + 12'd2;
        opc = {mem[pc], mem[pc + 12'd1]};
        x = opc[11:8];
        y = opc[7:4];
        nn = opc[7:0];
        nnn = opc[11:0];
        vx = vreg[x];
        vy = vreg[y];
        case (opc[15:12])
          FAM_SYS: begin
            if (opc == OPC_CLS) begin
              for (i = 0; i < 256; i++) begin
                if (disp[i] != 8'h00) chg = 1'b1;
                disp[i] = 8'h00;
              end
              pcv = nxt;
            end else if (opc == OPC_RET) begin
              pcv = stk[sp];
              sp = sp - 4'd1;
            end else begin
              ill = 1'b1;
            end
          end
          FAM_JP: pcv = nnn;
          FAM_CALL: begin
            sp = sp + 4'd1;
            stk[sp] = nxt;
            pcv = nnn;
          end
          FAM_SEB:  pcv = (vx == nn) ? nxt + 12'd2 : nxt;
          FAM_SNEB: pcv = (vx != nn) ? nxt + 12'd2 : nxt;
          FAM_SER:  pcv = (vx == vy) ? nxt + 12'd2 : nxt;
          FAM_SNER: pcv = (vx != vy) ? nxt + 12'd2 : nxt;
          FAM_LDB: begin
            vreg[x] = nn;
            pcv = nxt;
          end
          FAM_ADDB: begin
            vreg[x] = vx + nn;
            pcv = nxt;
          end
          FAM_ALU: begin
            setf = 1'b1;
            f = 1'b0;
            res = 8'h00;
            case (opc[3:0])
              ALU_MOV: begin res = vy; setf = 1'b0; end
              ALU_OR:  begin res = vx | vy; setf = 1'b0; end
              ALU_AND: begin res = vx & vy; setf = 1'b0; end
              ALU_XOR: begin res = vx ^ vy; setf = 1'b0; end
              ALU_ADD: begin
                sum = {1'b0, vx} + {1'b0, vy};
                res = sum[7:0];
                f = sum[8];
              end
              ALU_SUB:  begin res = vx - vy; f = (vx >= vy); end
              ALU_SHR:  begin res = vx >> 1; f = vx[0]; end
              ALU_SUBN: begin res = vy - vx; f = (vy >= vx); end
              ALU_SHL:  begin res = vx << 1; f = vx[7]; end
              default: ill = 1'b1;
            endcase
            if (!ill) begin
              // The flag is written last, so it wins when X is VF.
              vreg[x] = res;
              if (setf) vreg[15] = {7'd0, f};
              pcv = nxt;
            end
          end
          FAM_LDI: begin
            ireg = {4'd0, nnn};
            pcv = nxt;
          end
          FAM_JPV0: pcv = nnn + {4'd0, vreg[0]};
          FAM_RND: begin
            vreg[x] = c.rnd & nn;
            pcv = nxt;
          end
          FAM_DRW: begin
            // Sprite rows XOR onto the screen with wrap on both axes.
            hit = 1'b0;
            for (row = 0; row < opc[3:0]; row++) begin
              a = ireg[11:0] + row[11:0];
              line = mem[a];
              for (col = 0; col < 8; col++) begin
                if (line[7 - col]) begin
                  px = (vx + col) % 64;
                  py = (vy + row) % 32;
                  idx = py * 8 + px / 8;
                  bitm = 8'h80 >> (px % 8);
                  if ((disp[idx] & bitm) != 8'h00) hit = 1'b1;
                  disp[idx] = disp[idx] ^ bitm;
                  chg = 1'b1;
                end
              end
            end
            vreg[15] = {7'd0, hit};
            pcv = nxt;
          end
          FAM_KEY: begin
            if (nn == KEY_DOWN) pcv = c.keys[vx[3:0]] ? nxt + 12'd2 : nxt;
            else if (nn == KEY_UP) pcv = !c.keys[vx[3:0]] ? nxt + 12'd2 : nxt;
            else ill = 1'b1;
          end
          default: begin
            case (nn)
              MS_GETDT: vreg[x] = dtimer;
              MS_WAITK: vreg[x] = {4'd0, c.wkey};
              MS_SETDT: dtimer = vx;
              MS_SETST: stimer = vx;
              MS_ADDI:  ireg = ireg + {8'd0, vx};
              MS_FONT:  ireg = {5'd0, vx, 3'd0};
              MS_BCD: begin
                mem[ireg[11:0]] = vx / 100;
                mem[ireg[11:0] + 12'd1] = (vx % 100) / 10;
                mem[ireg[11:0] + 12'd2] = vx % 10;
              end
              MS_STORE:
                for (i = 0; i <= x; i++) mem[ireg[11:0] + i[11:0]] = vreg[i];
              MS_LOAD:
                for (i = 0; i <= x; i++) vreg[i] = mem[ireg[11:0] + i[11:0]];
              default: ill = 1'b1;
            endcase
            if (!ill) pcv = nxt;
          end
        endcase
        pc = pcv;
        if (dtimer != 8'h00) dtimer = dtimer - 8'd1;
        if (stimer != 8'h00) stimer = stimer - 8'd1;
        r.opc = opc;
      end
    endcase
    r.pc = pc;
    r.ill = ill;
    r.chg = chg;
    r.snd = (stimer != 8'h00);
  endtask

  task automatic add_cmd(input op_t op, input logic [11:0] addr, input logic [7:0] wdata,
                         input logic [15:0] keys, input logic [3:0] wkey,
                         input logic [7:0] rnd);
    cpu_cmd_t    c;
    cpu_status_t r;
    c = '{op: op, addr: addr, wdata: wdata, keys: keys, wkey: wkey, rnd: rnd};
    cpu_step(c, r);
    cmd_q.push_back(c);
    status_q.push_back(r);
  endtask

  // Stores an opcode at the current PC, then executes it.
  task automatic run_opcode(input logic [15:0] opc, input logic [15:0] keys,
                            input logic [3:0] wkey, input logic [7:0] rnd);
    logic [11:0] at;
    at = pc;
    add_cmd(OP_WRITE, at, opc[15:8], $urandom, $urandom, $urandom);
    add_cmd(OP_WRITE, at + 12'd1, opc[7:0], $urandom, $urandom, $urandom);
    add_cmd(OP_EXEC, $urandom, $urandom, keys, wkey, rnd);
  endtask

  function automatic logic [15:0] pick_opcode();
    logic [3:0]  fam;
    logic [11:0] body;
    int          k;
    logic [7:0]  subs [9];
    subs = '{MS_GETDT, MS_WAITK, MS_SETDT, MS_SETST, MS_ADDI, MS_FONT,
             MS_BCD, MS_STORE, MS_LOAD};
    fam = $urandom_range(15);
    body = $urandom;
    k = $urandom_range(99);
    case (fam)
      FAM_SYS: begin
        // Clearing is slow, so keep it rare.
        if (k < 2) return OPC_CLS;
        if (k < 55) return OPC_RET;
        return {FAM_SYS, body};
      end
      FAM_KEY: begin
        if (k < 45) return {FAM_KEY, body[11:8], KEY_DOWN};
        if (k < 90) return {FAM_KEY, body[11:8], KEY_UP};
        return {FAM_KEY, body};
      end
      FAM_MISC: begin
        if (k < 90) return {FAM_MISC, body[11:8], subs[$urandom_range(8)]};
        return {FAM_MISC, body};
      end
      default: return {fam, body};
    endcase
  endfunction

  // Input driver: one nonblocking update of valid per edge.
  always @(posedge clk) begin
    int idle;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) n_sent++;
      if (!in_tvalid || in_tready) begin
        idle = (n_sent < n_total / 3) ? 28 : (n_sent < 2 * n_total / 3) ? 82 : 0;
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle) begin
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, cmd_q.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
      n_fail++;
    end
  endtask

  // Output monitor with random backpressure.
  always @(posedge clk) begin
    int          stall;
    cpu_status_t e, g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        g = out_tdata[38:0];
        if (status_q.size() == 0) begin
          $error("result beat with no expectation: %h", out_tdata);
          n_fail++;
        end else begin
          e = status_q.pop_front();
          check_field("read_data", e.rd, g.rd);
          check_field("program_counter", e.pc, g.pc);
          check_field("executed_opcode", e.opc, g.opc);
          check_field("illegal_opcode", e.ill, g.ill);
          check_field("display_changed", e.chg, g.chg);
          check_field("sound_on", e.snd, g.snd);
        end
      end
      stall = (n_sent < n_total / 3) ? 82 : (n_sent < 2 * n_total / 3) ? 28 : 0;
      out_tready <= ($urandom_range(99) >= stall);
    end
  end

  initial begin
    int i, k, n;
    n_sent = 0;
    n_fail = 0;
    // Reset image of the shadow CPU: font glyphs at the bottom of memory.
    for (i = 0; i < 4096; i++) mem[i] = (i < 128) ? font_byte(i[6:0]) : 8'h00;
    for (i = 0; i < 256; i++) disp[i] = 8'h00;
    for (i = 0; i < 16; i++) begin
      vreg[i] = 8'h00;
      stk[i] = 12'h000;
    end
    ireg = '0;
    pc = PC_RESET;
    sp = 4'hF;
    dtimer = 8'h00;
    stimer = 8'h00;

    // Directed: address extremes, empty-memory fetch, draw, clear, stack underflow.
    add_cmd(OP_READ, 12'h000, 8'h00, 16'h0000, 4'h0, 8'h00);
    add_cmd(OP_READ, 12'hFFF, 8'h00, 16'h0000, 4'h0, 8'h00);
    add_cmd(OP_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 4'hF, 8'hFF);
    add_cmd(OP_READ, 12'hFFF, 8'h00, 16'h0000, 4'h0, 8'h00);
    add_cmd(OP_DISP, 12'hFFF, 8'h00, 16'h0000, 4'h0, 8'h00);
    add_cmd(OP_EXEC, 12'h000, 8'h00, 16'hFFFF, 4'hF, 8'hFF);
    run_opcode({FAM_DRW, 12'h015}, 16'h0000, 4'h0, 8'h00);
    add_cmd(OP_DISP, 12'h000, 8'h00, 16'h0000, 4'h0, 8'h00);
    run_opcode({FAM_LDB, 4'h3, 8'h3E}, 16'h0000, 4'h0, 8'h00);
    run_opcode({FAM_DRW, 4'h3, 4'h3, 4'hF}, 16'h0000, 4'h0, 8'h00);
    run_opcode(OPC_CLS, 16'h0000, 4'h0, 8'h00);
    run_opcode(OPC_RET, 16'h0000, 4'h0, 8'h00);
    add_cmd(OP_DISP, 12'h0FF, 8'h00, 16'h0000, 4'h0, 8'h00);

    // Random: mostly load-then-execute, with reads and blind fetches mixed in.
    n = 0;
    while (n < N_RANDOM) begin
      k = $urandom_range(99);
      if (k < 70) begin
        run_opcode(pick_opcode(), $urandom, $urandom, $urandom);
        n += 3;
      end else begin
        if (k < 82) add_cmd(OP_READ, (k < 76) ? ireg[11:0] + $urandom_range(15) : $urandom,
                            $urandom, $urandom, $urandom, $urandom);
        else if (k < 94) add_cmd(OP_DISP, $urandom, $urandom, $urandom, $urandom, $urandom);
        else add_cmd(OP_EXEC, $urandom, $urandom, $urandom, $urandom, $urandom);
        n++;
      end
    end
    n_total = cmd_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || status_q.size() > 0 || in_tvalid) @(posedge clk);
    repeat (600) @(posedge clk);
    if (n_fail == 0) $display("PASS chip8_instruction_executor");
    else $display("FAIL chip8_instruction_executor");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL chip8_instruction_executor");
    $finish;
  end
endmodule
